[hdl/plc_pkg.sv]
// ---------------------------------------------------------------------------
// plc_pkg: shared types for the positional list store
// Request codes and the shift command that is broadcast along the cell row.
// ---------------------------------------------------------------------------
package plc_pkg;

	// request codes; code 3 has no meaning and is rejected
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_READ   = 2'd2
	} plc_mode_t;

	// command seen by every cell in the same cycle
	typedef struct packed {
		logic       ins;   // insert accepted this cycle
		logic       rem;   // remove accepted this cycle
		logic [7:0] idx;   // 0-based target cell
	} plc_op_t;

endpackage

[hdl/plc_req_if.sv]
// ---------------------------------------------------------------------------
// plc_req_if: request channel
// Carries one request word: mode, 1-based position and payload.
// ---------------------------------------------------------------------------
interface plc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  position;
	logic [31:0] payload;

	modport source (output valid, output mode, output position, output payload, input ready);
	modport sink   (input valid, input mode, input position, input payload, output ready);
endinterface

[hdl/plc_rsp_if.sv]
// ---------------------------------------------------------------------------
// plc_rsp_if: result channel
// Carries one result word: ok flag, read data and the entry count.
// ---------------------------------------------------------------------------
interface plc_rsp_if #(
	parameter int CW = 5
);
	logic          valid;
	logic          ready;
	logic          ok;
	logic [31:0]   read_data;
	logic [CW-1:0] entry_count;

	modport source (output valid, output ok, output read_data, output entry_count, input ready);
	modport sink   (input valid, input ok, input read_data, input entry_count, output ready);
endinterface

[hdl/plc_cell.sv]
// ---------------------------------------------------------------------------
// plc_cell: one list entry
// Holds, loads the new word, takes its lower neighbour on insert or its
// upper neighbour on remove, according to its place relative to the target.
// ---------------------------------------------------------------------------
module plc_cell import plc_pkg::*; #(
	parameter int          W   = 32,
	parameter int unsigned IDX = 0
) (
	input  logic         clk,
	input  plc_op_t      op,
	input  logic [W-1:0] word,
	input  logic [W-1:0] lower,
	input  logic [W-1:0] upper,
	output logic [W-1:0] entry_q
);

	localparam logic [7:0] MY_IDX = 8'(IDX);

	// shift, load or hold
	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (op.idx == MY_IDX) begin
				entry_q <= word;
			end else if (op.idx < MY_IDX) begin
				entry_q <= lower;
			end
		end else if (op.rem) begin
			if (op.idx <= MY_IDX) begin
				entry_q <= upper;
			end
		end
	end

endmodule

[hdl/positional_list_store.sv]
// ---------------------------------------------------------------------------
// positional_list_store: ordered list addressed by 1-based position
// A row of entry cells with a shared insert/remove command and a result
// register.
// ---------------------------------------------------------------------------
// Usage
//   req carries mode (insert, remove, read), position and payload; rsp gives
//   one word per request: ok, read_data and entry_count after the request.
//   Insert takes positions 1 to count+1 and is refused when the list is full;
//   remove and read take positions 1 to count. A refused request changes
//   nothing, answers ok low and read_data zero.
//   The result is registered at the edge that takes the request, and all
//   cells shift or load at that same edge.
//   Throughput, set by the single result register, is one request per cycle
//   unless rsp stalls; each cell moves one word to its neighbour per cycle.
//   If rsp stalls, the result waits in its register and req.ready stays low
//   until it is taken; a request arriving with the stall cleared is taken in
//   the same cycle.
//   Reset empties the list (count zero, no result pending); entry contents
//   are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
module positional_list_store import plc_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	plc_req_if.sink   req,
	plc_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]        count_q;
	logic [ITEM_BITS-1:0] cell_q [DEPTH];
	logic [ITEM_BITS-1:0] word;
	logic [ITEM_BITS-1:0] sel_entry;
	logic [31:0]          sel_data;
	logic [8:0]           pos9;
	logic [8:0]           cnt9;
	logic [7:0]           idx;
	logic                 accept;
	logic                 ok_c;
	logic                 is_ins;
	logic                 is_rem;
	logic                 is_read;
	plc_op_t              op;

	logic                 rsp_valid_q;
	logic                 rsp_ok_q;
	logic [31:0]          rsp_data_q;
	logic [CW-1:0]        rsp_count_q;

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// request decode and range checks
	assign pos9 = {1'b0, req.position};
	assign cnt9 = 9'(count_q);
	assign idx  = req.position - 8'd1;

	always_comb begin
		is_ins  = 1'b0;
		is_rem  = 1'b0;
		is_read = 1'b0;
		ok_c    = 1'b0;
		unique case (req.mode)
			MODE_INSERT: begin
				is_ins = 1'b1;
				ok_c   = (count_q < CW'(DEPTH)) && (req.position != 8'd0)
				         && (pos9 <= cnt9 + 9'd1);
			end
			MODE_REMOVE: begin
				is_rem = 1'b1;
				ok_c   = (req.position != 8'd0) && (pos9 <= cnt9);
			end
			MODE_READ: begin
				is_read = 1'b1;
				ok_c    = (req.position != 8'd0) && (pos9 <= cnt9);
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	assign op.ins = accept && is_ins && ok_c;
	assign op.rem = accept && is_rem && ok_c;
	assign op.idx = idx;

	// payload fitted to the entry width
	for (genvar b = 0; b < ITEM_BITS; b++) begin : g_word
		if (b < 32) begin : g_in
			assign word[b] = req.payload[b];
		end else begin : g_pad
			assign word[b] = 1'b0;
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ITEM_BITS-1:0] lower;
		logic [ITEM_BITS-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = word;
		end else begin : g_mid_lo
			assign lower = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = cell_q[i];
		end else begin : g_mid_hi
			assign upper = cell_q[i+1];
		end
		plc_cell #(
			.W   (ITEM_BITS),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.word    (word),
			.lower   (lower),
			.upper   (upper),
			.entry_q (cell_q[i])
		);
	end

	// read selection, only used when the position is in range
	assign sel_entry = cell_q[idx[IW-1:0]];

	for (genvar b = 0; b < 32; b++) begin : g_rd
		if (b < ITEM_BITS) begin : g_bit
			assign sel_data[b] = sel_entry[b];
		end else begin : g_zero
			assign sel_data[b] = 1'b0;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.ins) begin
			count_q <= count_q + CW'(1);
		end else if (op.rem) begin
			count_q <= count_q - CW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_ok_q    <= ok_c;
			rsp_data_q  <= (is_read && ok_c) ? sel_data : 32'd0;
			rsp_count_q <= op.ins ? count_q + CW'(1)
			             : op.rem ? count_q - CW'(1) : count_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.read_data   = rsp_data_q;
	assign rsp.entry_count = rsp_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ok_c) |=> $stable(count_q))
		else $error("refused request changed the count");

	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_count_q == count_q)
		else $error("reported count differs from list count");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ok_q) |-> rsp_data_q == 32'd0)
		else $error("refused request returned data");
`endif

endmodule

[sim/plc_list_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plc_list_checker: result checker for the positional list store
// Watches both channels, keeps its own copy of the list, and works out
// the answer to every accepted request word. Each result word is matched
// against the oldest outstanding answer; mismatches are counted.
// ---------------------------------------------------------------------------
module plc_list_checker import plc_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	plc_req_if   req,
	plc_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   refused
);

	typedef struct packed {
		logic        ok;
		logic [31:0] read_data;
		logic [4:0]  entry_count;
	} list_answer_t;

	logic [31:0]  cells [DEPTH];
	logic [4:0]   held;
	list_answer_t answers [$];
	list_answer_t wanted;
	list_answer_t fresh;

	// apply one request to the shadow list and work out its answer
	task automatic apply_request(input logic [1:0] mode, input logic [7:0] pos,
			input logic [31:0] word, output list_answer_t ans);
		ans = '0;
		case (mode)
			MODE_INSERT: begin
				if (held < DEPTH && pos >= 1 && pos <= held + 1) begin
					// entries at pos and later move up one cell
					for (int i = DEPTH - 1; i > 0; i--)
						if (i >= pos && i <= held)
							cells[i] = cells[i - 1];
					cells[pos - 1] = word;
					held = held + 5'd1;
					ans.ok = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (pos >= 1 && pos <= held) begin
					// entries after pos move down one cell
					for (int i = 1; i < DEPTH; i++)
						if (i >= pos && i < held)
							cells[i - 1] = cells[i];
					held = held - 5'd1;
					ans.ok = 1'b1;
				end
			end
			MODE_READ: begin
				if (pos >= 1 && pos <= held) begin
					ans.read_data = cells[pos - 1];
					ans.ok        = 1'b1;
				end
			end
			default: begin
				// unused code, nothing changes
			end
		endcase
		ans.entry_count = held;
	endtask

	initial begin
		fail_count = 0;
		checked    = 0;
		refused    = 0;
		pending    = 0;
		held       = '0;
	end

	// compare result words first, then take in the request of this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = '0;
			answers.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: result word with none outstanding: ok=%0b data=%h count=%0d",
							rsp.ok, rsp.read_data, rsp.entry_count);
				end else begin
					wanted = answers.pop_front();
					checked++;
					if (rsp.ok !== wanted.ok || rsp.read_data !== wanted.read_data ||
							rsp.entry_count !== wanted.entry_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: want ok=%0b data=%h count=%0d, got ok=%0b data=%h count=%0d",
								wanted.ok, wanted.read_data, wanted.entry_count,
								rsp.ok, rsp.read_data, rsp.entry_count);
					end
				end
			end
			if (req.valid && req.ready) begin
				apply_request(req.mode, req.position, req.payload, fresh);
				answers.push_back(fresh);
				if (!fresh.ok)
					refused++;
			end
			pending = answers.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: top level for the positional list store
// Drives request words with random gaps and result back-pressure, first a
// short directed run over the edge cases, then random traffic that fills
// and empties the list, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module testbench;
	import plc_pkg::*;

	localparam int          DEPTH        = 16;
	localparam int          PHASE_ITEMS  = 275;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_CYCLES = 10;
	localparam logic [1:0]  MODE_UNUSED  = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	int fail_count;
	int pending;
	int checked;
	int refused;
	int send_idle_pct;
	int take_idle_pct;
	int cycle_count = 0;
	int sent        = 0;
	int full_fills  = 0;
	int tracked_count = 0;
	bit draining    = 1'b0;

	plc_req_if          req ();
	plc_rsp_if #(.CW(5)) rsp ();

	positional_list_store #(
		.DEPTH     (DEPTH),
		.ITEM_BITS (32)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	plc_list_checker #(
		.DEPTH (DEPTH)
	) list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.refused    (refused)
	);

	always #5 clk = ~clk;

	// result side back-pressure
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// present one request word, called and left at a falling edge
	task automatic send_word(input logic [1:0] mode, input logic [7:0] pos,
			input logic [31:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid    <= 1'b1;
		req.mode     <= mode;
		req.position <= pos;
		req.payload  <= word;
		do @(posedge clk); while (!req.ready);
		sent++;
		// follow the list size so positions can be aimed
		case (mode)
			MODE_INSERT: begin
				if (tracked_count < DEPTH && pos >= 1 && pos <= tracked_count + 1) begin
					tracked_count++;
					if (tracked_count == DEPTH)
						full_fills++;
				end
			end
			MODE_REMOVE: begin
				if (pos >= 1 && pos <= tracked_count)
					tracked_count--;
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// one random request word, drifting between full and empty
	task automatic random_word();
		logic [1:0]  mode;
		logic [7:0]  pos;
		logic [31:0] word;
		int          pick;
		bit          bad;
		if (tracked_count == DEPTH && $urandom_range(3) == 0)
			draining = 1'b1;
		if (tracked_count == 0 && $urandom_range(3) == 0)
			draining = 1'b0;
		pick = $urandom_range(99);
		if (pick < 3)
			mode = MODE_UNUSED;
		else if (pick < (draining ? 28 : 58))
			mode = MODE_INSERT;
		else if (pick < 83)
			mode = MODE_REMOVE;
		else
			mode = MODE_READ;
		bad = ($urandom_range(99) < 10);
		if (mode == MODE_UNUSED)
			pos = 8'($urandom_range(255, 0));
		else if (mode == MODE_INSERT)
			pos = !bad ? 8'($urandom_range(tracked_count + 1, 1)) :
				($urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(255, tracked_count + 2)));
		else if (bad || tracked_count == 0)
			pos = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255, tracked_count + 1));
		else
			pos = 8'($urandom_range(tracked_count, 1));
		pick = $urandom_range(19);
		word = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		send_word(mode, pos, word);
	endtask

	initial begin
		req.valid     = 1'b0;
		req.mode      = MODE_INSERT;
		req.position  = '0;
		req.payload   = '0;
		rsp.ready     = 1'b0;
		send_idle_pct = 12;
		take_idle_pct = 45;
		arst_n        = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list: every request refused, unused code too
		send_word(MODE_READ, 8'd1, $urandom);
		send_word(MODE_REMOVE, 8'd1, $urandom);
		send_word(MODE_INSERT, 8'd0, 32'hFFFF_FFFF);
		send_word(MODE_INSERT, 8'd2, $urandom);
		send_word(MODE_UNUSED, 8'd255, 32'hFFFF_FFFF);

		// fill to the brim, front, back and middle inserts
		send_word(MODE_INSERT, 8'd1, 32'hFFFF_FFFF);
		send_word(MODE_INSERT, 8'd1, 32'h0);
		for (int i = 3; i <= DEPTH; i++)
			send_word(MODE_INSERT, (i % 2) ? 8'(tracked_count + 1) : 8'd2, $urandom);

		// full list and the ends of the position range
		send_word(MODE_INSERT, 8'd1, $urandom);
		send_word(MODE_READ, 8'd16, $urandom);
		send_word(MODE_READ, 8'd17, $urandom);
		send_word(MODE_READ, 8'd2, $urandom);
		send_word(MODE_REMOVE, 8'd16, $urandom);
		send_word(MODE_REMOVE, 8'd0, $urandom);

		// sender busy, receiver stalling hard
		repeat (PHASE_ITEMS) random_word();

		// sender sparse the other way round, with one full drain midway
		send_idle_pct = 45;
		take_idle_pct = 12;
		repeat (PHASE_ITEMS / 2) random_word();
		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (PHASE_ITEMS - PHASE_ITEMS / 2) random_word();

		// back to back
		send_idle_pct = 0;
		take_idle_pct = 0;
		repeat (PHASE_ITEMS) random_word();

		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("summary: %0d requests in three idling phases, %0d results checked, %0d refused",
			sent, checked, refused);
		$display("summary: list filled to capacity %0d times, %0d mismatches", full_fills, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
hdl/plc_pkg.sv
hdl/plc_req_if.sv
hdl/plc_rsp_if.sv
hdl/plc_cell.sv
hdl/positional_list_store.sv
sim/plc_list_checker.sv
sim/testbench.sv
